FILE: rtl/gpc_pkg.sv
// Shared types, constants and modular helper for the grid path counter.
package gpc_pkg;

  localparam int unsigned CountW = 25;
  localparam int unsigned KindW  = 2;
  localparam int unsigned CfgW   = 10;
  localparam int unsigned IdxW   = 1;

  localparam logic [CountW-1:0] PathMod = 25'd20170805;

  localparam logic [KindW-1:0] KindBlocked = 2'd1;
  localparam logic [KindW-1:0] KindNoTurn  = 2'd2;

  localparam logic [IdxW-1:0] RegRowCount    = 1'b0;
  localparam logic [IdxW-1:0] RegColumnCount = 1'b1;

  // One entry of the line store: the counts and kind of the cell above.
  typedef struct packed {
    logic [CountW-1:0] left_paths;
    logic [CountW-1:0] top_paths;
    logic [KindW-1:0]  kind;
  } line_entry_t;

  // Sum of two residues, reduced once.
  function automatic logic [CountW-1:0] add_mod(input logic [CountW-1:0] a,
                                                input logic [CountW-1:0] b);
    logic [CountW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, PathMod}) begin
      return CountW'(s - {1'b0, PathMod});
    end
    return s[CountW-1:0];
  endfunction

endpackage

FILE: rtl/grid_path_count_no_turn.sv
// Grid path counter: one cell a cycle, line store in a RAM, result at the last cell.
// The count is written to the output register when the last cell leaves the compute stage.
// Throughput: one cell per cycle, set by the single read and single write port of the
// line store; a last cell waits only while an earlier count is still not taken.
// Reset clears positions, pipeline and output; grid size returns to 1x1.
// The line store is not cleared: every entry is written a row before it is read.
module grid_path_count_no_turn #(
  parameter int unsigned MAX_COLUMNS = 512,
  parameter int unsigned MAX_ROWS    = 512
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [gpc_pkg::IdxW-1:0]    cfg_index_i,
  input  logic [gpc_pkg::CfgW-1:0]    cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [gpc_pkg::KindW-1:0]   cell_kind_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [gpc_pkg::CountW-1:0]  path_count_o
);

  import gpc_pkg::*;

  localparam int unsigned CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned EntryW = $bits(line_entry_t);

  // Grid size and position of the next cell.
  logic [RW-1:0] last_row_q, last_row_d;
  logic [CW-1:0] last_col_q, last_col_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;

  // Compute stage.
  logic             s1_valid_q, s1_valid_d;
  logic [KindW-1:0] s1_kind_q;
  logic             s1_first_q, s1_row0_q, s1_col0_q, s1_last_q, s1_one_q;
  logic [CW-1:0]    s1_col_q;
  logic             fwd_q;
  line_entry_t      fwd_data_q;
  logic             s1_done;

  // Cell to the left.
  logic [CountW-1:0] prior_left_q, prior_top_q;
  logic [KindW-1:0]  prior_kind_q;

  // Output register.
  logic              out_valid_q, out_valid_d;
  logic [CountW-1:0] path_count_q;

  logic              in_accept;
  logic              at_last_col, at_last_row;
  logic [31:0]       wr_val;
  logic [EntryW-1:0] ram_rdata;
  line_entry_t       above, wr_entry;
  logic [CountW-1:0] left_paths, top_paths, result;

  assign in_accept  = in_valid_i && in_ready_o;
  assign s1_done    = s1_valid_q && (!s1_last_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_done;

  // Register writes store the clamped last index of the grid.
  always_comb begin
    wr_val     = 32'(cfg_wdata_i);
    last_row_d = last_row_q;
    last_col_d = last_col_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegRowCount: begin
          if (wr_val == 32'd0) begin
            last_row_d = '0;
          end else if (wr_val > 32'(MAX_ROWS)) begin
            last_row_d = RW'(MAX_ROWS - 1);
          end else begin
            last_row_d = RW'(wr_val - 32'd1);
          end
        end
        RegColumnCount: begin
          if (wr_val == 32'd0) begin
            last_col_d = '0;
          end else if (wr_val > 32'(MAX_COLUMNS)) begin
            last_col_d = CW'(MAX_COLUMNS - 1);
          end else begin
            last_col_d = CW'(wr_val - 32'd1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign at_last_col = (col_q == last_col_q);
  assign at_last_row = (row_q == last_row_q);

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (cfg_we_i) begin
      row_d = '0;
      col_d = '0;
    end else if (in_accept) begin
      if (at_last_col && at_last_row) begin
        row_d = '0;
        col_d = '0;
      end else if (at_last_col) begin
        col_d = '0;
        row_d = row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_done) begin
      s1_valid_d = 1'b0;
    end
  end

  gpc_ram #(
    .WIDTH(EntryW),
    .DEPTH(MAX_COLUMNS)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (s1_done),
    .waddr_i(s1_col_q),
    .wdata_i(wr_entry),
    .re_i   (in_accept),
    .raddr_i(col_q),
    .rdata_o(ram_rdata)
  );

  // A read that meets the write of the same column in the same cycle takes the new word.
  assign above = fwd_q ? fwd_data_q : line_entry_t'(ram_rdata);

  always_comb begin
    left_paths = '0;
    top_paths  = '0;
    if (s1_first_q) begin
      left_paths = CountW'(1);
      top_paths  = CountW'(1);
    end else if (s1_kind_q == KindBlocked) begin
      left_paths = '0;
      top_paths  = '0;
    end else if (s1_row0_q) begin
      left_paths = prior_left_q;
    end else if (s1_col0_q) begin
      top_paths = above.top_paths;
    end else begin
      left_paths = (prior_kind_q == KindNoTurn) ? prior_left_q
                                                : add_mod(prior_left_q, prior_top_q);
      top_paths  = (above.kind == KindNoTurn) ? above.top_paths
                                              : add_mod(above.left_paths, above.top_paths);
    end
  end

  assign wr_entry = '{left_paths: left_paths, top_paths: top_paths, kind: s1_kind_q};
  assign result   = s1_one_q ? CountW'(1) : add_mod(left_paths, top_paths);

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_done && s1_last_q) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_row_q   <= '0;
      last_col_q   <= '0;
      row_q        <= '0;
      col_q        <= '0;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      prior_left_q <= '0;
      prior_top_q  <= '0;
      prior_kind_q <= '0;
    end else begin
      last_row_q  <= last_row_d;
      last_col_q  <= last_col_d;
      row_q       <= row_d;
      col_q       <= col_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_done) begin
        prior_left_q <= left_paths;
        prior_top_q  <= top_paths;
        prior_kind_q <= s1_kind_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_kind_q  <= cell_kind_i;
      s1_first_q <= (row_q == '0) && (col_q == '0);
      s1_row0_q  <= (row_q == '0);
      s1_col0_q  <= (col_q == '0);
      s1_last_q  <= at_last_row && at_last_col;
      s1_one_q   <= (last_row_q == '0) && (last_col_q == '0);
      s1_col_q   <= col_q;
      fwd_q      <= s1_done && (s1_col_q == col_q);
      fwd_data_q <= wr_entry;
    end
    if (s1_done && s1_last_q) begin
      path_count_q <= result;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign path_count_o = path_count_q;

`ifndef NO_ASSERTIONS
  a_pos_in_grid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q <= last_row_q) && (col_q <= last_col_q))
    else $error("cell position outside the configured grid");

  a_cfg_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (row_q == '0) && (col_q == '0))
    else $error("register write did not restart the grid");

  a_single_cell : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_done && s1_last_q && s1_one_q) |=> (out_valid_o && path_count_o == CountW'(1)))
    else $error("single-cell grid did not give one path");

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (path_count_o < PathMod))
    else $error("path count not reduced below the modulus");
`endif

endmodule

FILE: rtl/gpc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module gpc_ram #(
  parameter int unsigned WIDTH = 52,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
